FILE: rtl/spsrch_pkg.sv
// Package for the shortest path search block.
// Holds default sizes, field widths, mode and status codes and the state
// encoding. No dependencies.
package spsrch_pkg;

  localparam int NODES_DEF      = 1024;
  localparam int MAX_DEGREE_DEF = 8;

  localparam int NODE_FW   = 10;
  localparam int WEIGHT_W  = 24;
  localparam int DIST_W    = 32;
  localparam int STATUS_W  = 2;
  localparam int MODE_W    = 2;

  localparam logic [DIST_W-1:0] DIST_INF = '1;

  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIND  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_PRED  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

  typedef enum logic [13:0] {
    S_IDLE    = 14'b00000000000001,
    S_CLR     = 14'b00000000000010,
    S_ADD_RD  = 14'b00000000000100,
    S_ADD_WR  = 14'b00000000001000,
    S_PRD_RD  = 14'b00000000010000,
    S_PRD_OUT = 14'b00000000100000,
    S_INIT    = 14'b00000001000000,
    S_SCAN    = 14'b00000010000000,
    S_SETTLE  = 14'b00000100000000,
    S_DEG     = 14'b00001000000000,
    S_EDGE    = 14'b00010000000000,
    S_EDGE_W  = 14'b00100000000000,
    S_NODE_W  = 14'b01000000000000,
    S_RESP    = 14'b10000000000000
  } state_t;

endpackage

FILE: rtl/shortest_path_search.sv
// Shortest path search top level: graph storage, search sequencer, output register.
// Depends on spsrch_pkg.
//
// Usage. The input channel (in_valid, in_stall, in_mode, in_node_a, in_node_b,
// in_weight) takes one command item at a time; every item gives exactly one
// result item on the output channel (out_valid, out_stall, out_status,
// out_distance, out_pred_node). in_stall stays high while an item is in work.
// Clear writes one degree entry per cycle. Add edge reads the node's degree
// and then writes the edge; read predecessor reads the node's entry. A search
// first initializes the distance memory, then for every settled node makes a
// full scan through the single distance memory port, settles the node, fetches
// its degree, relaxes each outgoing edge and closes its edge loop.
// Out of range searches and edges go straight to the result.
// After reset the block sweeps the degree memory with in_stall high and
// gives no result for it. A result sits in an output
// register; while out_stall is high it holds and the block may still take
// the next item, finishing its work up to the point of handing it over.
module shortest_path_search #(
  parameter int NODES      = spsrch_pkg::NODES_DEF,
  parameter int MAX_DEGREE = spsrch_pkg::MAX_DEGREE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [spsrch_pkg::MODE_W-1:0]   in_mode,
  input  logic [spsrch_pkg::NODE_FW-1:0]  in_node_a,
  input  logic [spsrch_pkg::NODE_FW-1:0]  in_node_b,
  input  logic [spsrch_pkg::WEIGHT_W-1:0] in_weight,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [spsrch_pkg::STATUS_W-1:0] out_status,
  output logic [spsrch_pkg::DIST_W-1:0]   out_distance,
  output logic [spsrch_pkg::NODE_FW-1:0]  out_pred_node
);
  import spsrch_pkg::*;

  localparam int NW = $clog2(NODES);
  localparam int CW = NW + 1;
  localparam int DW = $clog2(MAX_DEGREE + 1);
  localparam int EW = $clog2(NODES * MAX_DEGREE);
  localparam int SLOTS = NODES * MAX_DEGREE;

  // Memories: degree per node, edge lists, {settled, distance} per node and predecessor per node.
  logic [DW-1:0]         deg_mem  [NODES];
  logic [NW-1:0]         etgt_mem [SLOTS];
  logic [WEIGHT_W-1:0]   ewgt_mem [SLOTS];
  logic [DIST_W:0]       node_mem [NODES];
  logic [NW-1:0]         pred_mem [NODES];

  logic [DW-1:0]         deg_q_r;
  logic [NW-1:0]         etgt_q_r;
  logic [WEIGHT_W-1:0]   ewgt_q_r;
  logic [DIST_W:0]       node_q_r;
  logic [NW-1:0]         pred_q_r;

  logic                  deg_we;
  logic [NW-1:0]         deg_waddr, deg_raddr;
  logic [DW-1:0]         deg_wdata;
  logic                  edge_we;
  logic [EW-1:0]         edge_waddr, edge_raddr;
  logic                  node_we;
  logic [NW-1:0]         node_waddr, node_raddr;
  logic [DIST_W:0]       node_wdata;
  logic                  pred_we;

  state_t                state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic                  vld_r, vld_nxt;
  logic [NW-1:0]         idx_r, idx_nxt;
  logic                  found_r, found_nxt;
  logic [DIST_W-1:0]     best_r, best_nxt;
  logic [NW-1:0]         u_r, u_nxt;
  logic [DW-1:0]         deg_r, deg_nxt;
  logic [DW-1:0]         k_r, k_nxt;
  logic [NW-1:0]         v_r, v_nxt;
  logic [WEIGHT_W-1:0]   w_r, w_nxt;
  logic [MODE_W-1:0]     mode_r, mode_nxt;
  logic [NODE_FW-1:0]    a_r, a_nxt;
  logic [NODE_FW-1:0]    b_r, b_nxt;
  logic [WEIGHT_W-1:0]   wt_r, wt_nxt;
  logic                  a_ok_r, a_ok_nxt;
  logic                  resp_pend_r, resp_pend_nxt;
  logic [NODE_FW-1:0]    start_r, start_nxt;
  logic                  searched_r, searched_nxt;
  logic [STATUS_W-1:0]   res_st_r, res_st_nxt;
  logic [DIST_W-1:0]     res_d_r, res_d_nxt;
  logic [NODE_FW-1:0]    res_p_r, res_p_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_st_r, out_st_nxt;
  logic [DIST_W-1:0]     out_d_r, out_d_nxt;
  logic [NODE_FW-1:0]    out_p_r, out_p_nxt;

  logic                  in_acc;
  logic                  in_a_ok, in_b_ok;
  logic [DIST_W:0]       sum;
  logic [DIST_W-1:0]     nd;
  logic                  cand;
  logic [EW-1:0]         slot_u, slot_a;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign in_a_ok   = (32'(in_node_a) < NODES);
  assign in_b_ok   = (32'(in_node_b) < NODES);

  assign sum    = {1'b0, best_r} + {{(DIST_W+1-WEIGHT_W){1'b0}}, w_r};
  assign nd     = sum[DIST_W] ? DIST_INF : sum[DIST_W-1:0];
  assign cand   = vld_r && !node_q_r[DIST_W] && (node_q_r[DIST_W-1:0] != DIST_INF) &&
                  (!found_r || (node_q_r[DIST_W-1:0] < best_r));
  assign slot_u = EW'(u_r) * EW'(MAX_DEGREE) + EW'(k_r);
  assign slot_a = EW'(NW'(a_r)) * EW'(MAX_DEGREE) + EW'(deg_q_r);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    vld_nxt       = 1'b0;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    u_nxt         = u_r;
    deg_nxt       = deg_r;
    k_nxt         = k_r;
    v_nxt         = v_r;
    w_nxt         = w_r;
    mode_nxt      = mode_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    wt_nxt        = wt_r;
    a_ok_nxt      = a_ok_r;
    resp_pend_nxt = resp_pend_r;
    start_nxt     = start_r;
    searched_nxt  = searched_r;
    res_st_nxt    = res_st_r;
    res_d_nxt     = res_d_r;
    res_p_nxt     = res_p_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_st_nxt    = out_st_r;
    out_d_nxt     = out_d_r;
    out_p_nxt     = out_p_r;

    deg_we     = 1'b0;
    deg_waddr  = cnt_r[NW-1:0];
    deg_wdata  = '0;
    deg_raddr  = NW'(a_r);
    edge_we    = 1'b0;
    edge_waddr = slot_a;
    edge_raddr = slot_u;
    node_we    = 1'b0;
    node_waddr = cnt_r[NW-1:0];
    node_wdata = {1'b0, DIST_INF};
    node_raddr = cnt_r[NW-1:0];
    pred_we    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          mode_nxt   = in_mode;
          a_nxt      = in_node_a;
          b_nxt      = in_node_b;
          wt_nxt     = in_weight;
          a_ok_nxt   = in_a_ok;
          res_st_nxt = ST_OK;
          res_d_nxt  = '0;
          res_p_nxt  = '0;
          cnt_nxt    = '0;
          case (in_mode)
            MODE_CLEAR: begin
              resp_pend_nxt = 1'b1;
              state_nxt     = S_CLR;
            end
            MODE_ADD: begin
              if (in_a_ok && in_b_ok) begin
                state_nxt = S_ADD_RD;
              end else begin
                res_st_nxt = ST_FULL;
                state_nxt  = S_RESP;
              end
            end
            MODE_FIND: begin
              if (in_a_ok && in_b_ok) begin
                start_nxt    = in_node_a;
                searched_nxt = 1'b1;
                state_nxt    = S_INIT;
              end else begin
                res_st_nxt = ST_NONE;
                res_d_nxt  = DIST_INF;
                state_nxt  = S_RESP;
              end
            end
            default: begin
              state_nxt = S_PRD_RD;
            end
          endcase
        end
      end
      S_CLR: begin
        deg_we  = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(NODES - 1)) begin
          state_nxt     = resp_pend_r ? S_RESP : S_IDLE;
          resp_pend_nxt = 1'b0;
        end
      end
      S_ADD_RD: begin
        state_nxt = S_ADD_WR;
      end
      S_ADD_WR: begin
        if (32'(deg_q_r) >= MAX_DEGREE) begin
          res_st_nxt = ST_FULL;
        end else begin
          edge_we   = 1'b1;
          deg_we    = 1'b1;
          deg_waddr = NW'(a_r);
          deg_wdata = DW'(deg_q_r + 1'b1);
        end
        state_nxt = S_RESP;
      end
      S_PRD_RD: begin
        node_raddr = NW'(a_r);
        state_nxt  = S_PRD_OUT;
      end
      S_PRD_OUT: begin
        if (a_ok_r && (a_r != start_r) && searched_r &&
            (node_q_r[DIST_W-1:0] != DIST_INF)) begin
          res_d_nxt = node_q_r[DIST_W-1:0];
          res_p_nxt = NODE_FW'(pred_q_r);
        end else begin
          res_st_nxt = ST_NONE;
          res_d_nxt  = DIST_INF;
        end
        state_nxt = S_RESP;
      end
      S_INIT: begin
        node_we = 1'b1;
        if (cnt_r[NW-1:0] == NW'(a_r)) begin
          node_wdata = '0;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(NODES - 1)) begin
          cnt_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_r != CW'(NODES)) begin
          vld_nxt = 1'b1;
          idx_nxt = cnt_r[NW-1:0];
          cnt_nxt = cnt_r + 1'b1;
        end else if (!vld_r) begin
          state_nxt = S_SETTLE;
        end
        if (cand) begin
          found_nxt = 1'b1;
          best_nxt  = node_q_r[DIST_W-1:0];
          u_nxt     = idx_r;
        end
      end
      S_SETTLE: begin
        deg_raddr = u_r;
        if (!found_r) begin
          res_st_nxt = ST_NONE;
          res_d_nxt  = DIST_INF;
          state_nxt  = S_RESP;
        end else begin
          node_we    = 1'b1;
          node_waddr = u_r;
          node_wdata = {1'b1, best_r};
          if (u_r == NW'(b_r)) begin
            res_d_nxt = best_r;
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_DEG;
          end
        end
      end
      S_DEG: begin
        deg_nxt   = deg_q_r;
        k_nxt     = '0;
        state_nxt = S_EDGE;
      end
      S_EDGE: begin
        if (k_r >= deg_r || 32'(k_r) >= MAX_DEGREE) begin
          cnt_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_EDGE_W;
        end
      end
      S_EDGE_W: begin
        node_raddr = etgt_q_r;
        v_nxt      = etgt_q_r;
        w_nxt      = ewgt_q_r;
        state_nxt  = S_NODE_W;
      end
      S_NODE_W: begin
        node_waddr = v_r;
        node_wdata = {node_q_r[DIST_W], nd};
        if (nd < node_q_r[DIST_W-1:0]) begin
          node_we = 1'b1;
          pred_we = 1'b1;
        end
        k_nxt     = DW'(k_r + 1'b1);
        state_nxt = S_EDGE;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_st_nxt    = res_st_r;
          out_d_nxt     = res_d_r;
          out_p_nxt     = res_p_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Memory ports: one write and one registered read per memory.
  always_ff @(posedge clk) begin
    if (deg_we) begin
      deg_mem[deg_waddr] <= deg_wdata;
    end
    deg_q_r <= deg_mem[deg_raddr];
    if (edge_we) begin
      etgt_mem[edge_waddr] <= NW'(b_r);
      ewgt_mem[edge_waddr] <= wt_r;
    end
    etgt_q_r <= etgt_mem[edge_raddr];
    ewgt_q_r <= ewgt_mem[edge_raddr];
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    node_q_r <= node_mem[node_raddr];
    if (pred_we) begin
      pred_mem[v_r] <= u_r;
    end
    pred_q_r <= pred_mem[NW'(a_r)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= '0;
      vld_r       <= 1'b0;
      found_r     <= 1'b0;
      resp_pend_r <= 1'b0;
      start_r     <= '0;
      searched_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      vld_r       <= vld_nxt;
      found_r     <= found_nxt;
      resp_pend_r <= resp_pend_nxt;
      start_r     <= start_nxt;
      searched_r  <= searched_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    best_r   <= best_nxt;
    u_r      <= u_nxt;
    deg_r    <= deg_nxt;
    k_r      <= k_nxt;
    v_r      <= v_nxt;
    w_r      <= w_nxt;
    mode_r   <= mode_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    wt_r     <= wt_nxt;
    a_ok_r   <= a_ok_nxt;
    res_st_r <= res_st_nxt;
    res_d_r  <= res_d_nxt;
    res_p_r  <= res_p_nxt;
    out_st_r <= out_st_nxt;
    out_d_r  <= out_d_nxt;
    out_p_r  <= out_p_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_st_r;
  assign out_distance  = out_d_r;
  assign out_pred_node = out_p_r;

  // A full-list answer never carries a distance; a missing path always reads as infinite.
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r == ST_FULL) |-> (out_d_r == '0))
    else $error("edge list full result carries a distance");

  a_none_inf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r == ST_NONE) |-> (out_d_r == DIST_INF))
    else $error("no path result without infinite distance");

  a_found_finite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SETTLE && found_r) |-> (best_r != DIST_INF))
    else $error("settled node has infinite distance");

  a_relax_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_NODE_W) |=> (state_r == S_EDGE && k_r == DW'($past(k_r) + 1'b1)))
    else $error("edge index did not advance after relaxation");

  // Only a search item ever reaches the scan.
  a_mode_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (mode_r == MODE_FIND))
    else $error("scan entered outside a search item");

endmodule

FILE: test/shortest_path_search_tb.sv
// Testbench for shortest_path_search: drives graph commands, predicts every
// result with a behavioral model that runs a Dijkstra search and checks each result item.
// Depends on spsrch_pkg and the shortest_path_search RTL.
module shortest_path_search_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import spsrch_pkg::*;

  localparam int WATCHDOG_LIMIT = 300000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DIST_W-1:0]   distance;
    logic [NODE_FW-1:0]  pred_node;
  } path_result_t;

  class path_scoreboard;
    int unsigned  degree[NODES_DEF];
    logic [NODE_FW-1:0]  edge_dst[NODES_DEF*MAX_DEGREE_DEF];
    logic [WEIGHT_W-1:0] edge_len[NODES_DEF*MAX_DEGREE_DEF];
    logic [DIST_W-1:0]   cost[NODES_DEF];
    logic [NODE_FW-1:0]  prev[NODES_DEF];
    bit                  done[NODES_DEF];
    logic [NODE_FW-1:0]  origin;
    path_result_t        pending[$];
    int                  errors;

    function new();
      foreach (degree[i]) begin
        degree[i] = 0;
        cost[i] = DIST_INF;
        prev[i] = '0;
        done[i] = 0;
      end
      origin = '0;
      errors = 0;
    endfunction

    // Settles nodes in (distance, id) order; true once the target is settled.
    function bit dijkstra(logic [NODE_FW-1:0] src, logic [NODE_FW-1:0] dst);
      int u;
      bit any;
      logic [DIST_W-1:0] bd;
      logic [DIST_W:0] sum;
      logic [DIST_W-1:0] nd;
      int slot;
      foreach (cost[i]) begin
        cost[i] = DIST_INF;
        done[i] = 0;
      end
      origin = src;
      cost[src] = '0;
      forever begin
        any = 0;
        u = 0;
        bd = DIST_INF;
        for (int i = 0; i < NODES_DEF; i++) begin
          if (!done[i] && cost[i] != DIST_INF && (!any || cost[i] < bd)) begin
            any = 1;
            bd = cost[i];
            u = i;
          end
        end
        if (!any) return 0;
        done[u] = 1;
        if (u == dst) return 1;
        for (int k = 0; k < degree[u]; k++) begin
          slot = u * MAX_DEGREE_DEF + k;
          sum = {1'b0, bd} + (DIST_W+1)'(edge_len[slot]);
          nd = sum[DIST_W] ? DIST_INF : sum[DIST_W-1:0];
          if (nd < cost[edge_dst[slot]]) begin
            cost[edge_dst[slot]] = nd;
            prev[edge_dst[slot]] = u[NODE_FW-1:0];
          end
        end
      end
    endfunction

    function void note_item(logic [MODE_W-1:0] mode, logic [NODE_FW-1:0] a,
                            logic [NODE_FW-1:0] b, logic [WEIGHT_W-1:0] w);
      path_result_t r;
      r = '{status: ST_OK, distance: '0, pred_node: '0};
      case (mode)
        MODE_CLEAR: begin
          foreach (degree[i]) degree[i] = 0;
        end
        MODE_ADD: begin
          if (degree[a] >= MAX_DEGREE_DEF) begin
            r.status = ST_FULL;
          end else begin
            edge_dst[a * MAX_DEGREE_DEF + degree[a]] = b;
            edge_len[a * MAX_DEGREE_DEF + degree[a]] = w;
            degree[a]++;
          end
        end
        MODE_FIND: begin
          if (dijkstra(a, b)) begin
            r.distance = cost[b];
          end else begin
            r.status = ST_NONE;
            r.distance = DIST_INF;
          end
        end
        default: begin
          if (a != origin && cost[a] != DIST_INF) begin
            r.distance = cost[a];
            r.pred_node = prev[a];
          end else begin
            r.status = ST_NONE;
            r.distance = DIST_INF;
          end
        end
      endcase
      pending = {pending, r};
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(path_result_t got);
      path_result_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected result, status", got.status, 0);
      end else begin
        want = pending.pop_front();
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        if (got.distance !== want.distance)
          report_mismatch("distance", got.distance, want.distance);
        if (got.pred_node !== want.pred_node)
          report_mismatch("pred_node", got.pred_node, want.pred_node);
      end
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  logic [MODE_W-1:0] in_mode = MODE_CLEAR;
  logic [NODE_FW-1:0] in_node_a = '0;
  logic [NODE_FW-1:0] in_node_b = '0;
  logic [WEIGHT_W-1:0] in_weight = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [STATUS_W-1:0] out_status;
  logic [DIST_W-1:0] out_distance;
  logic [NODE_FW-1:0] out_pred_node;

  path_scoreboard paths = new();
  int send_idle_pct = 30;
  int recv_idle_pct = 65;
  int quiet_cycles = 0;
  logic [NODE_FW-1:0] pool[10];

  shortest_path_search u_top (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      paths.note_item(in_mode, in_node_a, in_node_b, in_weight);
    if (rst_n && out_valid && !out_stall)
      paths.check_result('{status: out_status, distance: out_distance,
                           pred_node: out_pred_node});
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Offers one item and holds it until accepted; may idle afterwards.
  task send(logic [MODE_W-1:0] mode, logic [NODE_FW-1:0] a, logic [NODE_FW-1:0] b,
            logic [WEIGHT_W-1:0] w);
    in_valid <= 1;
    in_mode <= mode;
    in_node_a <= a;
    in_node_b <= b;
    in_weight <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Lets the item accepted last be noted first, then waits until every pending result is checked.
  task drain();
    in_valid <= 0;
    @(posedge clk);
    while (paths.pending.size() != 0) @(posedge clk);
  endtask

  function logic [WEIGHT_W-1:0] pick_weight();
    return ($urandom_range(1) != 0) ? WEIGHT_W'($urandom_range(0, 4095))
                                    : WEIGHT_W'($urandom());
  endfunction

  task random_phase(int count);
    int pick;
    foreach (pool[i]) pool[i] = NODE_FW'($urandom());
    send(MODE_CLEAR, NODE_FW'($urandom()), NODE_FW'($urandom()), WEIGHT_W'($urandom()));
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 45)
        send(MODE_ADD, pool[$urandom_range(9)], pool[$urandom_range(9)], pick_weight());
      else if (pick < 50)
        send(MODE_ADD, pool[$urandom_range(9)], NODE_FW'($urandom()), pick_weight());
      else if (pick < 75)
        send(MODE_FIND, pool[$urandom_range(9)], pool[$urandom_range(9)],
             WEIGHT_W'($urandom()));
      else if (pick < 93)
        send(MODE_PRED, pool[$urandom_range(9)], NODE_FW'($urandom()),
             WEIGHT_W'($urandom()));
      else if (pick < 97)
        send(MODE_PRED, NODE_FW'($urandom()), NODE_FW'($urandom()), WEIGHT_W'($urandom()));
      else
        send(MODE_CLEAR, NODE_FW'($urandom()), NODE_FW'($urandom()), WEIGHT_W'($urandom()));
    end
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1;

    // A search where start equals target, then reads of the start and of an
    // unreached node; both have no predecessor.
    send(MODE_FIND, 10'd5, 10'd5, 24'd0);
    send(MODE_PRED, 10'd5, 10'd0, 24'd0);
    send(MODE_PRED, 10'd7, 10'd0, 24'd0);
    // Extreme nodes and weights, a self loop, and a duplicate edge that is a
    // strict improvement.
    send(MODE_ADD, 10'd0, 10'd1023, 24'hFFFFFF);
    send(MODE_ADD, 10'd1023, 10'd0, 24'd0);
    send(MODE_ADD, 10'd0, 10'd1, 24'h400);
    send(MODE_ADD, 10'd1, 10'd1023, 24'h3FF);
    send(MODE_ADD, 10'd1, 10'd1, 24'd1);
    send(MODE_ADD, 10'd0, 10'd1, 24'h200);
    send(MODE_FIND, 10'd0, 10'd1023, 24'd0);
    send(MODE_PRED, 10'd1023, 10'd0, 24'd0);
    send(MODE_PRED, 10'd1, 10'd0, 24'd0);
    send(MODE_PRED, 10'd0, 10'd0, 24'd0);
    send(MODE_FIND, 10'd2, 10'd0, 24'd0);
    // Node 3 fills its edge list; the last add is refused.
    for (int k = 0; k <= MAX_DEGREE_DEF; k++)
      send(MODE_ADD, 10'd3, 10'd4, WEIGHT_W'($urandom()));
    send(MODE_FIND, 10'd3, 10'd4, 24'd0);
    send(MODE_CLEAR, 10'h3FF, 10'h3FF, 24'hFFFFFF);
    send(MODE_FIND, 10'd0, 10'd1023, 24'd0);
    drain();

    random_phase(25);
    send_idle_pct = 65;
    recv_idle_pct = 30;
    random_phase(25);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(24);

    repeat (50) @(posedge clk);
    if (paths.errors == 0 && paths.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
